FILE: design/three_rotor_enigma_cipher_defines.svh
// Assertion macros shared by the Enigma cipher checker.
`ifndef THREE_ROTOR_ENIGMA_CIPHER_DEFINES_SVH
`define THREE_ROTOR_ENIGMA_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ENIGMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ENIGMA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/enigma_pkg.sv
// Types, wiring tables and modulo-26 helpers for the Enigma cipher.
package enigma_pkg;

    localparam int LETTER_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [LETTER_W-1:0] LETTERS = 5'd26;
    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIDDLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RIGHT = 2'd2;

    // Reset start positions
    localparam logic [LETTER_W-1:0] RST_LEFT = 5'd2;
    localparam logic [LETTER_W-1:0] RST_MIDDLE = 5'd20;
    localparam logic [LETTER_W-1:0] RST_RIGHT = 5'd16;

    typedef logic [LETTER_W-1:0] letter_t;

    // One queued word: reduced letter plus rotor positions after stepping
    typedef struct packed {
        letter_t letter;
        letter_t pos_l;
        letter_t pos_m;
        letter_t pos_r;
    } enigma_item_t;

    // Rotor wirings, forward and inverse, and reflector B
    localparam letter_t ROT_I [26] = '{
        5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
        5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9};
    localparam letter_t ROT_II [26] = '{
        5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
        5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4};
    localparam letter_t ROT_III [26] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
        5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
    localparam letter_t INV_I [26] = '{
        5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
        5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9};
    localparam letter_t INV_II [26] = '{
        5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
        5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18};
    localparam letter_t INV_III [26] = '{
        5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
        5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};
    localparam letter_t REFL_B [26] = '{
        5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6, 5'd14,
        5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9, 5'd0, 5'd19};

    // Reduce a 5-bit value to 0..25
    function automatic letter_t mod26(input letter_t x);
        letter_t t;
        t = x - LETTERS;
        return (x >= LETTERS) ? t : x;
    endfunction

    // Step one position with wraparound
    function automatic letter_t inc26(input letter_t x);
        letter_t t;
        t = x + 5'd1;
        return (x == LAST_LETTER) ? 5'd0 : t;
    endfunction

    // (a + b) mod 26, both in range
    function automatic letter_t add26(input letter_t a, input letter_t b);
        logic [LETTER_W:0] s;
        logic [LETTER_W:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - {1'b0, LETTERS};
        return (s >= {1'b0, LETTERS}) ? t[LETTER_W-1:0] : s[LETTER_W-1:0];
    endfunction

    // (a - b) mod 26, both in range
    function automatic letter_t sub26(input letter_t a, input letter_t b);
        logic [LETTER_W:0] s;
        letter_t d;
        s = {1'b0, a} + {1'b0, LETTERS} - {1'b0, b};
        d = a - b;
        return (a >= b) ? d : s[LETTER_W-1:0];
    endfunction

endpackage

FILE: design/enigma_front.sv
// Front end: start registers, rotor stepping and word intake.
module enigma_front
    import enigma_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  letter_t              cfg_data,
    input  logic                 in_valid,
    input  letter_t              in_letter,
    input  logic                 in_start,
    input  logic                 q_full,
    output logic                 in_ready,
    output logic                 q_push,
    output enigma_item_t         q_item
);

    letter_t start_l_reg, start_m_reg, start_r_reg;
    letter_t pos_l_reg, pos_m_reg, pos_r_reg;
    letter_t pos_l_next, pos_m_next, pos_r_next;
    letter_t sl, sm, sr;
    letter_t base_l, base_m, base_r;

    assign in_ready = !q_full;
    assign q_push = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_l_reg <= RST_LEFT;
            start_m_reg <= RST_MIDDLE;
            start_r_reg <= RST_RIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_LEFT:   start_l_reg <= cfg_data;
                CFG_START_MIDDLE: start_m_reg <= cfg_data;
                CFG_START_RIGHT:  start_r_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stepping: reload on message start, then odometer with turnover at start positions
    always_comb
    begin
        sl = mod26(start_l_reg);
        sm = mod26(start_m_reg);
        sr = mod26(start_r_reg);
        base_l = in_start ? sl : pos_l_reg;
        base_m = in_start ? sm : pos_m_reg;
        base_r = in_start ? sr : pos_r_reg;
        pos_r_next = inc26(base_r);
        pos_m_next = base_m;
        pos_l_next = base_l;
        if (pos_r_next == sr)
        begin
            pos_m_next = inc26(base_m);
            if (pos_m_next == sm)
            begin
                pos_l_next = inc26(base_l);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_l_reg <= RST_LEFT;
            pos_m_reg <= RST_MIDDLE;
            pos_r_reg <= RST_RIGHT;
        end
        else if (q_push)
        begin
            pos_l_reg <= pos_l_next;
            pos_m_reg <= pos_m_next;
            pos_r_reg <= pos_r_next;
        end
    end

    // Word handed to the queue
    always_comb
    begin
        q_item.letter = mod26(in_letter);
        q_item.pos_l = pos_l_next;
        q_item.pos_m = pos_m_next;
        q_item.pos_r = pos_r_next;
    end

endmodule

FILE: design/enigma_fifo.sv
// Small register queue between the front end and the substitution pipeline.
module enigma_fifo
    import enigma_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  enigma_item_t wr_item,
    input  logic         pop,
    output enigma_item_t rd_item,
    output logic         empty,
    output logic         full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    enigma_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full = (cnt_reg == CNT_FULL);
    assign rd_item = mem_reg[head_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= wr_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/enigma_back.sv
// Back end: four-stage substitution pipeline through rotors and reflector.
module enigma_back
    import enigma_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  enigma_item_t q_item,
    output logic         q_pop,
    output logic         out_valid,
    output letter_t      out_letter,
    input  logic         out_ready
);

    // Stage registers
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    letter_t b1_reg, l1_reg, m1_reg, r1_reg;
    letter_t rf2_reg, l2_reg, m2_reg, r2_reg;
    letter_t e3_reg, r3_reg;
    letter_t f_reg;

    letter_t b1_next, rf2_next, e3_next, f_next;
    letter_t a_s, c_s, d_s, inv1_s, inv2_s, inv3_s;

    logic ld1, ld2, ld3, ldo;

    // Stall chain: a stage loads when its successor is empty or moving
    assign ldo = v3_reg && (!vo_reg || out_ready);
    assign ld3 = v2_reg && (!v3_reg || ldo);
    assign ld2 = v1_reg && (!v2_reg || ld3);
    assign ld1 = !q_empty && (!v1_reg || ld2);
    assign q_pop = ld1;

    assign out_valid = vo_reg;
    assign out_letter = f_reg;

    // Stage 1: rotor III then rotor II forward
    always_comb
    begin
        a_s = ROT_III[add26(q_item.pos_r, q_item.letter)];
        b1_next = ROT_II[sub26(add26(q_item.pos_m, a_s), q_item.pos_r)];
    end

    // Stage 2: rotor I forward then reflector
    always_comb
    begin
        c_s = ROT_I[sub26(add26(l1_reg, b1_reg), m1_reg)];
        rf2_next = REFL_B[sub26(c_s, l1_reg)];
    end

    // Stage 3: rotor I and II inverse
    always_comb
    begin
        inv1_s = INV_I[add26(rf2_reg, l2_reg)];
        d_s = sub26(inv1_s, l2_reg);
        inv2_s = INV_II[add26(d_s, m2_reg)];
        e3_next = sub26(inv2_s, m2_reg);
    end

    // Stage 4: rotor III inverse into the output register
    always_comb
    begin
        inv3_s = INV_III[add26(e3_reg, r3_reg)];
        f_next = sub26(inv3_s, r3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ld1 || ld2)
            begin
                v1_reg <= ld1;
            end
            if (ld2 || ld3)
            begin
                v2_reg <= ld2;
            end
            if (ld3 || ldo)
            begin
                v3_reg <= ld3;
            end
            if (ldo || out_ready)
            begin
                vo_reg <= ldo;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            b1_reg <= b1_next;
            l1_reg <= q_item.pos_l;
            m1_reg <= q_item.pos_m;
            r1_reg <= q_item.pos_r;
        end
        if (ld2)
        begin
            rf2_reg <= rf2_next;
            l2_reg <= l1_reg;
            m2_reg <= m1_reg;
            r2_reg <= r1_reg;
        end
        if (ld3)
        begin
            e3_reg <= e3_next;
            r3_reg <= r2_reg;
        end
        if (ldo)
        begin
            f_reg <= f_next;
        end
    end

endmodule

FILE: design/three_rotor_enigma_cipher.sv
// An accepted word is queued, then registered in stages 1, 2 and 3 and the output register.
// Throughput: one letter per cycle unless stalled; rotors step on each accepted word
// and the four-stage substitution pipeline behind the queue takes one word a cycle.
// Output backpressure fills the pipeline and then the queue before s_tready drops.
// Reset (rst_n low, async): starts and positions 2/20/16, queue and pipeline empty.
module three_rotor_enigma_cipher
    import enigma_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LETTER_W-1:0]  cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [4:0] letter_in
    input  logic                 s_tuser,   // [0] message_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata    // [4:0] letter_out
);

    enigma_item_t push_item, pop_item;
    logic push, pop, q_empty, q_full;
    letter_t letter_out;

    enigma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_letter (s_tdata[LETTER_W-1:0]),
        .in_start  (s_tuser),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .q_push    (push),
        .q_item    (push_item)
    );

    enigma_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (pop_item),
        .empty   (q_empty),
        .full    (q_full)
    );

    enigma_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (pop_item),
        .q_pop      (pop),
        .out_valid  (m_tvalid),
        .out_letter (letter_out),
        .out_ready  (m_tready)
    );

    assign m_tdata = {3'b000, letter_out};

endmodule

FILE: design/enigma_checker.sv
// Port-level checker for the Enigma cipher, bound to the top level.
`include "three_rotor_enigma_cipher_defines.svh"

module enigma_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [7:0]           m_tdata
);

    logic [7:0] pend_reg;
    logic in_acc, out_acc;

    assign in_acc = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {7'd0, in_acc} - {7'd0, out_acc};
        end
    end

    `ENIGMA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `ENIGMA_ASSERT_IMP(a_out_range, m_tvalid, m_tdata[7:5] == 3'b000 && m_tdata[4:0] < 5'd26, "output letter out of range")
    `ENIGMA_ASSERT_IMP(a_no_phantom, m_tvalid, pend_reg != 8'd0, "output word with no accepted input")
    `ENIGMA_ASSERT_IMP(a_idle_ready, pend_reg == 8'd0, s_tready, "input not ready while block is empty")

endmodule

bind three_rotor_enigma_cipher enigma_checker u_enigma_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the three-rotor Enigma cipher stream block.
module testbench;
    import enigma_pkg::*;

    localparam int STALL_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam logic [5:0] USE_PREDICTOR = 6'h3f;

    // Rotor wirings I, II, III, their inverses, and reflector B
    localparam int WIRE_I [26] = '{4, 10, 12, 5, 11, 6, 3, 16, 21, 25, 13, 19, 14,
                                   22, 24, 7, 23, 20, 18, 15, 0, 8, 1, 17, 2, 9};
    localparam int WIRE_II [26] = '{0, 9, 3, 10, 18, 8, 17, 20, 23, 1, 11, 7, 22,
                                    19, 12, 2, 16, 6, 25, 13, 15, 24, 5, 21, 14, 4};
    localparam int WIRE_III [26] = '{1, 3, 5, 7, 9, 11, 2, 15, 17, 19, 23, 21, 25,
                                     13, 24, 4, 8, 22, 6, 0, 10, 12, 20, 18, 16, 14};
    localparam int BACK_I [26] = '{20, 22, 24, 6, 0, 3, 5, 15, 21, 25, 1, 4, 2,
                                   10, 12, 19, 7, 23, 18, 11, 17, 8, 13, 16, 14, 9};
    localparam int BACK_II [26] = '{0, 9, 15, 2, 25, 22, 17, 11, 5, 1, 3, 10, 14,
                                    19, 24, 20, 16, 6, 4, 13, 7, 23, 12, 8, 21, 18};
    localparam int BACK_III [26] = '{19, 0, 6, 1, 15, 2, 18, 3, 16, 4, 20, 5, 21,
                                     13, 25, 7, 24, 8, 23, 9, 22, 11, 17, 10, 14, 12};
    localparam int REFLECT_B [26] = '{24, 17, 20, 7, 16, 18, 11, 3, 15, 23, 13, 6, 14,
                                      10, 12, 8, 4, 1, 5, 25, 2, 22, 21, 9, 0, 19};

    // Directed probe: letter, message start, known answer or USE_PREDICTOR
    typedef struct packed {
        logic [4:0] letter;
        logic       start;
        logic [5:0] known;
    } probe_t;

    localparam int NUM_PROBES = 24;
    localparam probe_t PROBES [NUM_PROBES] = '{
        '{5'd0,  1'b0, 6'd16},          // no message start since reset
        '{5'd16, 1'b1, 6'd0},           // reload to start, reciprocal of the first
        '{5'd25, 1'b0, USE_PREDICTOR},
        '{5'd26, 1'b0, USE_PREDICTOR},  // letters past z wrap around
        '{5'd27, 1'b0, USE_PREDICTOR},
        '{5'd28, 1'b0, USE_PREDICTOR},
        '{5'd29, 1'b0, USE_PREDICTOR},
        '{5'd30, 1'b0, USE_PREDICTOR},
        '{5'd31, 1'b0, USE_PREDICTOR},
        '{5'd31, 1'b1, USE_PREDICTOR},
        '{5'd26, 1'b1, USE_PREDICTOR},
        '{5'd0,  1'b1, USE_PREDICTOR},
        '{5'd25, 1'b1, USE_PREDICTOR},
        '{5'd13, 1'b0, USE_PREDICTOR},
        '{5'd7,  1'b0, USE_PREDICTOR},
        '{5'd21, 1'b0, USE_PREDICTOR},
        '{5'd4,  1'b0, USE_PREDICTOR},
        '{5'd16, 1'b0, USE_PREDICTOR},
        '{5'd10, 1'b0, USE_PREDICTOR},
        '{5'd0,  1'b0, USE_PREDICTOR},
        '{5'd25, 1'b0, USE_PREDICTOR},
        '{5'd5,  1'b1, USE_PREDICTOR},
        '{5'd5,  1'b0, USE_PREDICTOR},
        '{5'd5,  1'b0, USE_PREDICTOR}
    };

    // Start settings per random phase: left, middle, right
    localparam int NUM_PHASES = 5;
    localparam logic [4:0] PHASE_STARTS [NUM_PHASES][3] = '{
        '{5'd0,  5'd0,  5'd0},
        '{5'd25, 5'd25, 5'd25},
        '{5'd31, 5'd31, 5'd31},
        '{5'd9,  5'd28, 5'd3},
        '{5'd26, 5'd7,  5'd30}
    };

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_LEFT;
    logic [LETTER_W-1:0]  cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;   // [4:0] letter_in
    logic                 s_tuser = 1'b0; // [0] message_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;        // [4:0] letter_out

    // Shadow registers and rotor positions of the predictor
    int start_l = 2;
    int start_m = 20;
    int start_r = 16;
    int rotor_l = 2;
    int rotor_m = 20;
    int rotor_r = 16;

    logic [4:0] cipher_q [$];
    logic [5:0] known_q [$];
    int err_cnt = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 62;
    bit stall_req = 1'b0;

    three_rotor_enigma_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Step the rotors and pass one letter through the machine
    function automatic logic [4:0] encipher_letter(input logic [4:0] raw, input logic reload);
        int x, sl, sm, sr, a, b, c, r, d, e, f;
        x = int'(raw) % 26;
        sl = start_l % 26;
        sm = start_m % 26;
        sr = start_r % 26;
        if (reload)
        begin
            rotor_l = sl;
            rotor_m = sm;
            rotor_r = sr;
        end
        rotor_r = (rotor_r + 1) % 26;
        // Middle turns as the right comes back to its start; left likewise
        if (rotor_r == sr)
        begin
            rotor_m = (rotor_m + 1) % 26;
            if (rotor_m == sm)
                rotor_l = (rotor_l + 1) % 26;
        end
        a = WIRE_III[(rotor_r + x) % 26];
        b = WIRE_II[(rotor_m + a + 26 - rotor_r) % 26];
        c = WIRE_I[(rotor_l + b + 26 - rotor_m) % 26];
        r = REFLECT_B[(c + 26 - rotor_l) % 26];
        d = (BACK_I[(r + rotor_l) % 26] + 26 - rotor_l) % 26;
        e = (BACK_II[(d + rotor_m) % 26] + 26 - rotor_m) % 26;
        f = (BACK_III[(e + rotor_r) % 26] + 26 - rotor_r) % 26;
        return f[4:0];
    endfunction

    // Monitor: predict on input words, check output words
    always @(posedge clk)
    begin
        logic [4:0] predicted;
        logic [5:0] known;
        logic [4:0] want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_LEFT:   start_l = int'(cfg_data);
                    CFG_START_MIDDLE: start_m = int'(cfg_data);
                    CFG_START_RIGHT:  start_r = int'(cfg_data);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predicted = encipher_letter(s_tdata[4:0], s_tuser);
                known = known_q.pop_front();
                cipher_q.push_back((known == USE_PREDICTOR) ? predicted : known[4:0]);
            end
            if (m_tvalid && m_tready)
            begin
                if (cipher_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("ERROR: unexpected output word %0d", m_tdata);
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (m_tdata !== {3'b000, want})
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("ERROR: letter_out expected %0d got %0d", want, m_tdata);
                    end
                end
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offer one word, with a random gap ahead of it, until it is taken
    task automatic send_word(input logic [4:0] letter, input logic start, input logic [5:0] known);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        known_q.push_back(known);
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, letter};
        s_tuser <= start;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_drain();
        while (cipher_q.size() != 0 || known_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_starts(input logic [4:0] l, input logic [4:0] m, input logic [4:0] r);
        cfg_we <= 1'b1;
        cfg_index <= CFG_START_LEFT;
        cfg_data <= l;
        @(posedge clk);
        cfg_index <= CFG_START_MIDDLE;
        cfg_data <= m;
        @(posedge clk);
        cfg_index <= CFG_START_RIGHT;
        cfg_data <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Messages of random length; a long one reaches the left rotor turnover
    task automatic send_messages(input int count, input bit one_long);
        int left, len;
        logic [4:0] letter;
        logic start;
        bit first;
        left = count;
        first = 1'b1;
        while (left > 0)
        begin
            len = one_long ? left : $urandom_range(40, 1);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                // sometimes carry on from the previous setting without a reload
                start = (i == 0) && !(first && $urandom_range(9) < 3);
                if (!one_long && i != 0 && $urandom_range(24) == 0)
                    start = 1'b1;
                letter = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                  : 5'($urandom_range(25));
                send_word(letter, start, USE_PREDICTOR);
            end
            first = 1'b0;
            left -= len;
        end
        s_tvalid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes at the reset setting
        for (int i = 0; i < NUM_PROBES; i++)
            send_word(PROBES[i].letter, PROBES[i].start, PROBES[i].known);
        s_tvalid <= 1'b0;
        wait_drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 15;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_starts(PHASE_STARTS[p][0], PHASE_STARTS[p][1], PHASE_STARTS[p][2]);
            if (p == 1)
                stall_req = 1'b1;
            send_messages((p == NUM_PHASES - 1) ? 720 : 60, p == NUM_PHASES - 1);
            wait_drain();
        end

        repeat (10) @(posedge clk);
        if (err_cnt == 0 && cipher_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
